@@ rtl/smbus_master_byte_sequencer_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the SMBus master byte sequencer
// Concurrent checks on clk with rst_n low masking them; empty when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef SMBUS_MASTER_BYTE_SEQUENCER_TOP_MACROS_SVH
`define SMBUS_MASTER_BYTE_SEQUENCER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define SMBMS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("smbms: check failed");
// consequent holds in the same cycle as the antecedent
`define SMBMS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smbms: check failed");
// consequent holds in the cycle after the antecedent
`define SMBMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smbms: check failed");
`else
`define SMBMS_ASSERT_ALWAYS(lbl, cond)
`define SMBMS_ASSERT_IMPL(lbl, ante, cons)
`define SMBMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/smbms_pkg.sv @@
// ---------------------------------------------------------------------------
// smbms_pkg
// Types, codes and constants shared by the SMBus master byte sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package smbms_pkg;

  localparam int BUF_DEPTH_DEF = 16;
  localparam int COUNT_CAP     = 30;
  localparam int CNT_EXT_W     = 7;    // holds any depth up to 64 and its index math

  localparam logic [7:0] ADDR_MASK = 8'hFE;
  localparam logic [7:0] ERR_MAX   = 8'hFF;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // host / bus function codes
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_START = 2'd1;
  localparam logic [1:0] FN_EVENT = 2'd2;
  localparam logic [1:0] FN_READ  = 2'd3;

  // bus status classes
  localparam logic [1:0] SC_START_SENT = 2'd0;
  localparam logic [1:0] SC_DATA_SENT  = 2'd1;
  localparam logic [1:0] SC_BYTE_RECV  = 2'd2;
  localparam logic [1:0] SC_OTHER      = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] index;
    logic [7:0] value;
    logic [7:0] target_address;
    logic       direction;
    logic [4:0] byte_count;
    logic       clear_errors;
    logic [1:0] status_class;
    logic       ack_in;
    logic       arb_lost;
    logic [7:0] rx_byte;
  } in_item_t;

  // one result before the buffer read data is merged in
  typedef struct packed {
    logic [7:0] drive_data;
    logic       load_data;
    logic       set_start;
    logic       clear_start;
    logic       set_stop;
    logic       ack_out;
    logic       reset_ctrl;
    logic       busy_res;
    logic [7:0] error_count;
    logic       accepted;
    logic       use_tx;     // drive_data comes from the transmit buffer
    logic       use_rx;     // read_value comes from the receive buffer
  } res_t;

  typedef struct packed {
    logic tx_we;
    logic tx_re;
    logic rx_we;
    logic rx_re;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/smbms_ram.sv @@
// ---------------------------------------------------------------------------
// smbms_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// ---------------------------------------------------------------------------
`default_nettype none

module smbms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/smbms_ctrl.sv @@
// ---------------------------------------------------------------------------
// smbms_ctrl
// Transfer state, counters and per-item decode; drives the buffer ports.
// ---------------------------------------------------------------------------
`default_nettype none

`include "smbus_master_byte_sequencer_top_macros.svh"

module smbms_ctrl #(
  parameter int BUF_DEPTH = smbms_pkg::BUF_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_accept,
  input  wire smbms_pkg::in_item_t          item,
  output smbms_pkg::res_t                   res,
  output smbms_pkg::mem_ctl_t               mem_ctl,
  output logic [$clog2(BUF_DEPTH)-1:0]      tx_waddr,
  output logic [$clog2(BUF_DEPTH)-1:0]      tx_raddr,
  output logic [$clog2(BUF_DEPTH)-1:0]      rx_waddr,
  output logic [$clog2(BUF_DEPTH)-1:0]      rx_raddr
);

  import smbms_pkg::*;

  localparam int AW  = $clog2(BUF_DEPTH);
  localparam int CAP = (BUF_DEPTH > COUNT_CAP) ? COUNT_CAP : BUF_DEPTH;
  localparam logic [CNT_EXT_W-1:0] DEPTH_X = CNT_EXT_W'(BUF_DEPTH);
  localparam logic [CNT_EXT_W-1:0] CAP_X   = CNT_EXT_W'(CAP);

  state_t     state_r, state_nxt;
  logic [7:0] slave_address_r, slave_address_nxt;
  logic       read_mode_r, read_mode_nxt;
  logic [4:0] length_r, length_nxt;
  logic [4:0] sent_count_r, sent_count_nxt;
  logic [4:0] recv_count_r, recv_count_nxt;
  logic [7:0] errors_r, errors_nxt;

  logic [CNT_EXT_W-1:0] idx_x;
  logic [CNT_EXT_W-1:0] sent_p;
  logic [CNT_EXT_W-1:0] recv_p;
  logic [7:0]           err_inc;
  mem_ctl_t             mem_req;

  assign idx_x   = {{(CNT_EXT_W-4){1'b0}}, item.index};
  assign sent_p  = {{(CNT_EXT_W-5){1'b0}}, sent_count_r} - CNT_EXT_W'(1);
  assign recv_p  = (recv_count_r != 5'd0) ?
                   {{(CNT_EXT_W-5){1'b0}}, recv_count_r} - CNT_EXT_W'(1) : '0;
  assign err_inc = errors_r + {7'd0, (errors_r != ERR_MAX)};

  assign tx_waddr = idx_x[AW-1:0];
  assign tx_raddr = sent_p[AW-1:0];
  assign rx_waddr = recv_p[AW-1:0];
  assign rx_raddr = idx_x[AW-1:0];

  always_comb begin
    state_nxt         = state_r;
    slave_address_nxt = slave_address_r;
    read_mode_nxt     = read_mode_r;
    length_nxt        = length_r;
    sent_count_nxt    = sent_count_r;
    recv_count_nxt    = recv_count_r;
    errors_nxt        = errors_r;
    mem_req           = '0;
    res               = '0;
    res.accepted      = 1'b1;

    unique case (item.func)
      FN_LOAD: begin
        mem_req.tx_we = (idx_x < DEPTH_X);
      end
      FN_START: begin
        if (state_r == ST_BUSY) begin
          res.accepted = 1'b0;
        end else begin
          slave_address_nxt = item.target_address;
          read_mode_nxt     = item.direction;
          length_nxt        = ({2'b00, item.byte_count} > CAP_X) ? 5'(CAP) : item.byte_count;
          if (item.clear_errors) begin
            errors_nxt = '0;
          end
          state_nxt     = ST_BUSY;
          res.set_start = 1'b1;
        end
      end
      FN_EVENT: begin
        priority if (item.arb_lost || item.status_class == SC_OTHER) begin
          // bus failure: bounce the interface and count it
          res.reset_ctrl  = 1'b1;
          res.clear_start = 1'b1;
          state_nxt       = ST_IDLE;
          errors_nxt      = err_inc;
        end else if (item.status_class == SC_START_SENT) begin
          res.drive_data  = (slave_address_r & ADDR_MASK) | {7'd0, read_mode_r};
          res.load_data   = 1'b1;
          res.clear_start = 1'b1;
          sent_count_nxt  = 5'd1;
          recv_count_nxt  = 5'd1;
        end else if (item.status_class == SC_DATA_SENT) begin
          if (item.ack_in) begin
            if (!read_mode_r) begin
              if (sent_count_r != 5'd0 && sent_count_r <= length_r) begin
                mem_req.tx_re  = 1'b1;
                res.use_tx     = 1'b1;
                res.load_data  = 1'b1;
                sent_count_nxt = sent_count_r + 5'd1;
              end else begin
                res.set_stop = 1'b1;
                state_nxt    = ST_IDLE;
              end
            end
          end else begin
            res.set_stop = 1'b1;
            state_nxt    = ST_IDLE;
            errors_nxt   = err_inc;
          end
        end else begin
          // byte received: store, then ACK or finish with NACK and stop
          mem_req.rx_we = (recv_p < DEPTH_X);
          if (recv_count_r < length_r) begin
            res.ack_out    = 1'b1;
            recv_count_nxt = recv_count_r + 5'd1;
          end else begin
            state_nxt    = ST_IDLE;
            res.set_stop = 1'b1;
          end
        end
      end
      FN_READ: begin
        mem_req.rx_re = (idx_x < DEPTH_X);
        res.use_rx    = mem_req.rx_re;
      end
      default: begin
        res.accepted = 1'b1;
      end
    endcase

    res.busy_res    = (state_nxt == ST_BUSY);
    res.error_count = errors_nxt;
  end

  assign mem_ctl.tx_we = mem_req.tx_we & in_accept;
  assign mem_ctl.tx_re = mem_req.tx_re & in_accept;
  assign mem_ctl.rx_we = mem_req.rx_we & in_accept;
  assign mem_ctl.rx_re = mem_req.rx_re & in_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      slave_address_r <= '0;
      read_mode_r     <= 1'b0;
      length_r        <= '0;
      sent_count_r    <= 5'd1;
      recv_count_r    <= 5'd1;
      errors_r        <= '0;
    end else if (in_accept) begin
      state_r         <= state_nxt;
      slave_address_r <= slave_address_nxt;
      read_mode_r     <= read_mode_nxt;
      length_r        <= length_nxt;
      sent_count_r    <= sent_count_nxt;
      recv_count_r    <= recv_count_nxt;
      errors_r        <= errors_nxt;
    end
  end

  `SMBMS_ASSERT_ALWAYS(a_len_capped, length_r <= 5'(CAP))
  `SMBMS_ASSERT_NEXT(a_refused_start_keeps, in_accept && item.func == FN_START && state_r == ST_BUSY, state_r == ST_BUSY && length_r == $past(length_r))
  `SMBMS_ASSERT_NEXT(a_errors_monotone, !(in_accept && item.func == FN_START), errors_r >= $past(errors_r))

endmodule

`default_nettype wire

@@ rtl/smbms_out.sv @@
// ---------------------------------------------------------------------------
// smbms_out
// Two-entry result pipe: a decode stage that waits on the buffer read data,
// then the output register toward the master-side channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "smbus_master_byte_sequencer_top_macros.svh"

module smbms_out (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_accept,
  input  wire smbms_pkg::res_t                       res,
  input  wire logic [7:0]                            tx_rdata,
  input  wire logic [7:0]                            rx_rdata,
  output logic                                       in_ready,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [smbms_pkg::OUT_DATA_W-1:0]           out_data
);

  import smbms_pkg::*;

  logic                  a_valid_r;
  res_t                  a_res_r;
  logic                  b_valid_r;
  logic [OUT_DATA_W-1:0] b_data_r, b_data_nxt;
  logic                  b_free;
  logic                  a_adv;
  logic [7:0]            drive;
  logic [7:0]            rdval;

  assign b_free   = !b_valid_r || out_ready;
  assign a_adv    = a_valid_r && b_free;
  assign in_ready = !a_valid_r || a_adv;

  // merge buffer read data, which arrives with stage A
  assign drive = a_res_r.use_tx ? tx_rdata : a_res_r.drive_data;
  assign rdval = a_res_r.use_rx ? rx_rdata : 8'd0;

  assign b_data_nxt = {a_res_r.accepted, rdval, a_res_r.error_count,
                       a_res_r.busy_res, a_res_r.reset_ctrl, a_res_r.ack_out,
                       a_res_r.set_stop, a_res_r.clear_start, a_res_r.set_start,
                       a_res_r.load_data, drive};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        b_valid_r <= 1'b1;
      end else if (out_ready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_res_r <= res;
    end
    if (a_adv) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

  `SMBMS_ASSERT_IMPL(a_stall_only_full, !in_ready, a_valid_r && b_valid_r)
  `SMBMS_ASSERT_NEXT(a_advance_fills_out, a_adv, b_valid_r)

endmodule

`default_nettype wire

@@ rtl/smbus_master_byte_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// smbus_master_byte_sequencer_top
// Master-side byte sequencer of an SMBus/I2C controller: host accesses
// and byte-level bus events in, bus actions and readback out.
// ---------------------------------------------------------------------------
//  channel  dir  handshake                payload
//  in_      in   in_tvalid / in_tready    in_tdata[39:0], in_tuser[1:0] = func
//  out_     out  out_tvalid / out_tready  out_tdata[31:0]
//
//  One item per cycle sustained while out_tready is high; each result goes
//  through the decode stage (with transmit/receive buffer read), then output reg.
//  Reset (rst_n low, synchronous) idles the sequencer, resets the byte
//  counters to one, clears the error count; buffer contents are not cleared.
//  in_tready drops only while both the decode stage and the output register
//  hold results and out_tready is low.
// ---------------------------------------------------------------------------
`default_nettype none

module smbus_master_byte_sequencer_top #(
  parameter int BUF_DEPTH = smbms_pkg::BUF_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // index[3:0], value[11:4], target_address[19:12], direction[20],
  // byte_count[25:21], clear_errors[26], status_class[28:27], ack_in[29],
  // arb_lost[30], rx_byte[38:31], zero[39]
  input  wire logic [smbms_pkg::IN_DATA_W-1:0]   in_tdata,
  // func[1:0]
  input  wire logic [smbms_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // drive_data[7:0], load_data[8], set_start[9], clear_start[10], set_stop[11],
  // ack_out[12], reset_ctrl[13], busy_res[14], error_count[22:15],
  // read_value[30:23], accepted[31]
  output logic [smbms_pkg::OUT_DATA_W-1:0]       out_tdata
);

  import smbms_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);

  logic     in_accept;
  in_item_t item;
  res_t     res;
  mem_ctl_t mem_ctl;
  logic [AW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
  logic [7:0]    tx_rdata, rx_rdata;

  assign in_accept = in_tvalid && in_tready;

  assign item.func           = in_tuser;
  assign item.index          = in_tdata[3:0];
  assign item.value          = in_tdata[11:4];
  assign item.target_address = in_tdata[19:12];
  assign item.direction      = in_tdata[20];
  assign item.byte_count     = in_tdata[25:21];
  assign item.clear_errors   = in_tdata[26];
  assign item.status_class   = in_tdata[28:27];
  assign item.ack_in         = in_tdata[29];
  assign item.arb_lost       = in_tdata[30];
  assign item.rx_byte        = in_tdata[38:31];

  smbms_ctrl #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .item      (item),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .tx_waddr  (tx_waddr),
    .tx_raddr  (tx_raddr),
    .rx_waddr  (rx_waddr),
    .rx_raddr  (rx_raddr)
  );

  smbms_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_tx_buf (
    .clk   (clk),
    .we    (mem_ctl.tx_we),
    .waddr (tx_waddr),
    .wdata (item.value),
    .re    (mem_ctl.tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  smbms_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_rx_buf (
    .clk   (clk),
    .we    (mem_ctl.rx_we),
    .waddr (rx_waddr),
    .wdata (item.rx_byte),
    .re    (mem_ctl.rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  smbms_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .res       (res),
    .tx_rdata  (tx_rdata),
    .rx_rdata  (rx_rdata),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

@@ tb/tb_smbus_master_byte_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// tb_smbus_master_byte_sequencer_top
// Streams host accesses and bus events into the byte sequencer and checks
// every bus action item against an in-bench model of the sequencer.
// A short directed table runs first, then random write and read transfers,
// noise, broken transfers and an error storm that drives the counter into
// saturation. Sender bursts and receiver stalls are random.
// ---------------------------------------------------------------------------

module tb_smbus_master_byte_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smbms_pkg::*;

  localparam int LEN_CAP    = (BUF_DEPTH_DEF < COUNT_CAP) ? BUF_DEPTH_DEF : COUNT_CAP;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_GOAL  = 1000;

  // out_tdata layout, lowest field last
  typedef struct packed {
    logic       accepted;
    logic [7:0] read_value;
    logic [7:0] error_count;
    logic       busy_res;
    logic       reset_ctrl;
    logic       ack_out;
    logic       set_stop;
    logic       clear_start;
    logic       set_start;
    logic       load_data;
    logic [7:0] drive_data;
  } bus_action_t;

  typedef struct packed {
    in_item_t    it;
    logic        typed;
    bus_action_t want;
  } dir_row_t;

  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_SELDOM, RDY_PERIODIC} ready_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  smbus_master_byte_sequencer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // sequencer model state
  logic [7:0]  txb [BUF_DEPTH_DEF];
  logic [7:0]  rxb [BUF_DEPTH_DEF];
  logic [15:0] tx_written;
  logic [15:0] rx_written;
  logic [7:0]  m_addr;
  logic        m_read;
  logic [4:0]  m_len;
  logic [4:0]  m_sent;
  logic [4:0]  m_recv;
  logic        m_busy;
  logic [7:0]  m_errors;

  bus_action_t pending_actions[$];
  in_item_t    cur_item;
  logic        cur_typed = 1'b0;
  bus_action_t cur_want;
  int          fails = 0;
  int          n_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  ready_mode_t rdy_mode = RDY_ALWAYS;
  int          rdy_left = 0;

  function automatic void count_error();
    if (m_errors != ERR_MAX) m_errors = m_errors + 8'd1;
  endfunction

  function automatic bus_action_t predict_bus_action(in_item_t it);
    bus_action_t r;
    logic [4:0]  n;
    logic [4:0]  p;
    r = '0;
    r.accepted = 1'b1;
    case (it.func)
      FN_LOAD: begin
        txb[it.index] = it.value;
        tx_written[it.index] = 1'b1;
      end
      FN_START: begin
        if (m_busy) begin
          r.accepted = 1'b0;
        end else begin
          n = (it.byte_count > 5'(LEN_CAP)) ? 5'(LEN_CAP) : it.byte_count;
          m_addr = it.target_address;
          m_read = it.direction;
          m_len  = n;
          if (it.clear_errors) m_errors = '0;
          m_busy = 1'b1;
          r.set_start = 1'b1;
        end
      end
      FN_EVENT: begin
        if (it.arb_lost || it.status_class == SC_OTHER) begin
          r.reset_ctrl = 1'b1;
          r.clear_start = 1'b1;
          m_busy = 1'b0;
          count_error();
        end else if (it.status_class == SC_START_SENT) begin
          r.drive_data = (m_addr & ADDR_MASK) | {7'd0, m_read};
          r.load_data = 1'b1;
          r.clear_start = 1'b1;
          m_sent = 5'd1;
          m_recv = 5'd1;
        end else if (it.status_class == SC_DATA_SENT) begin
          if (it.ack_in) begin
            // write transfer: next byte or stop; a read transfer ignores the address ack
            if (!m_read) begin
              if (m_sent >= 5'd1 && m_sent <= m_len) begin
                r.drive_data = txb[4'(m_sent - 5'd1)];
                r.load_data = 1'b1;
                m_sent = m_sent + 5'd1;
              end else begin
                r.set_stop = 1'b1;
                m_busy = 1'b0;
              end
            end
          end else begin
            r.set_stop = 1'b1;
            m_busy = 1'b0;
            count_error();
          end
        end else begin
          p = (m_recv >= 5'd1) ? m_recv - 5'd1 : 5'd0;
          if (p < 5'(BUF_DEPTH_DEF)) begin
            rxb[p[3:0]] = it.rx_byte;
            rx_written[p[3:0]] = 1'b1;
          end
          if (m_recv < m_len) begin
            r.ack_out = 1'b1;
            m_recv = m_recv + 5'd1;
          end else begin
            m_busy = 1'b0;
            r.set_stop = 1'b1;
          end
        end
      end
      default: begin
        r.read_value = rxb[it.index];
      end
    endcase
    r.busy_res = m_busy;
    r.error_count = m_errors;
    return r;
  endfunction

  function automatic in_item_t mk_item(int f, int idx, int val, int addr, int dir, int cnt,
                                       int clr, int sc, int ack, int arb, int rx);
    in_item_t it;
    it.func           = f[1:0];
    it.index          = idx[3:0];
    it.value          = val[7:0];
    it.target_address = addr[7:0];
    it.direction      = dir[0];
    it.byte_count     = cnt[4:0];
    it.clear_errors   = clr[0];
    it.status_class   = sc[1:0];
    it.ack_in         = ack[0];
    it.arb_lost       = arb[0];
    it.rx_byte        = rx[7:0];
    return it;
  endfunction

  function automatic bus_action_t mk_act(int drive, int load, int sstart, int cstart, int sstop,
                                         int ackout, int rst, int busy, int err, int rd,
                                         int acc);
    bus_action_t r;
    r.drive_data  = drive[7:0];
    r.load_data   = load[0];
    r.set_start   = sstart[0];
    r.clear_start = cstart[0];
    r.set_stop    = sstop[0];
    r.ack_out     = ackout[0];
    r.reset_ctrl  = rst[0];
    r.busy_res    = busy[0];
    r.error_count = err[7:0];
    r.read_value  = rd[7:0];
    r.accepted    = acc[0];
    return r;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.func           = 2'($urandom_range(0, 3));
    it.index          = 4'($urandom_range(0, 15));
    it.value          = 8'($urandom_range(0, 255));
    it.target_address = 8'($urandom_range(0, 255));
    it.direction      = 1'($urandom_range(0, 1));
    it.byte_count     = 5'($urandom_range(0, 31));
    it.clear_errors   = 1'($urandom_range(0, 1));
    it.status_class   = 2'($urandom_range(0, 3));
    it.ack_in         = 1'($urandom_range(0, 1));
    it.arb_lost       = 1'($urandom_range(0, 1));
    it.rx_byte        = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // a write data event that would fetch a transmit entry never loaded
  function automatic bit needs_tx_fill(in_item_t it);
    return it.func == FN_EVENT && !it.arb_lost && it.status_class == SC_DATA_SENT &&
           it.ack_in && !m_read && m_sent >= 5'd1 && m_sent <= m_len &&
           !tx_written[4'(m_sent - 5'd1)];
  endfunction

  task automatic drive_item(in_item_t it, logic typed, bus_action_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    cur_item  = it;
    cur_typed = typed;
    cur_want  = want;
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {1'b0, it.rx_byte, it.arb_lost, it.ack_in, it.status_class, it.clear_errors,
                  it.byte_count, it.direction, it.target_address, it.value, it.index};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    n_sent++;
  endtask

  task automatic send(in_item_t it, logic typed, bus_action_t want);
    in_item_t fill;
    @(negedge clk);
    if (needs_tx_fill(it)) begin
      fill = rand_item();
      fill.func  = FN_LOAD;
      fill.index = 4'(m_sent - 5'd1);
      drive_item(fill, 1'b0, '0);
      @(negedge clk);
    end
    // read back only entries that hold a received byte
    if (it.func == FN_READ && !rx_written[it.index]) begin
      if (rx_written == '0) begin
        it.func = FN_LOAD;
      end else begin
        do it.index = 4'($urandom_range(0, 15)); while (!rx_written[it.index]);
      end
    end
    drive_item(it, typed, want);
  endtask

  task automatic send_event(logic [1:0] sc, logic ack, logic arb);
    in_item_t it;
    it = rand_item();
    it.func = FN_EVENT;
    it.status_class = sc;
    it.ack_in = ack;
    it.arb_lost = arb;
    send(it, 1'b0, '0);
  endtask

  task automatic send_start(logic dir, logic [4:0] cnt);
    in_item_t it;
    it = rand_item();
    it.func = FN_START;
    it.direction = dir;
    it.byte_count = cnt;
    it.clear_errors = ($urandom_range(0, 15) == 0);
    send(it, 1'b0, '0);
  endtask

  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 5'($urandom_range(0, 4));
    if (r < 18) return 5'($urandom_range(5, 16));
    return 5'($urandom_range(17, 31));
  endfunction

  function automatic logic rare_fail();
    return $urandom_range(0, 39) == 0;
  endfunction

  task automatic run_write();
    logic [4:0] cnt;
    int         len;
    int         k;
    logic       ack;
    logic       arb;
    in_item_t   it;
    cnt = pick_count();
    len = (cnt > 5'(LEN_CAP)) ? LEN_CAP : int'(cnt);
    if (len > 0) begin
      repeat ($urandom_range(0, len)) begin
        it = rand_item();
        it.func = FN_LOAD;
        it.index = 4'($urandom_range(0, len - 1));
        send(it, 1'b0, '0);
      end
    end
    send_start(1'b0, cnt);
    send_event(SC_START_SENT, 1'($urandom_range(0, 1)), rare_fail());
    for (k = 0; k <= len; k++) begin
      ack = ($urandom_range(0, 19) != 0);
      arb = rare_fail();
      send_event(SC_DATA_SENT, ack, arb);
      if (!ack || arb) break;
    end
  endtask

  task automatic run_read();
    logic [4:0] cnt;
    int         len;
    in_item_t   it;
    cnt = pick_count();
    len = (cnt > 5'(LEN_CAP)) ? LEN_CAP : int'(cnt);
    if (len == 0) len = 1;
    send_start(1'b1, cnt);
    send_event(SC_START_SENT, 1'($urandom_range(0, 1)), rare_fail());
    send_event(SC_DATA_SENT, 1'b1, rare_fail());
    repeat (len) send_event(SC_BYTE_RECV, 1'($urandom_range(0, 1)), rare_fail());
    repeat ($urandom_range(0, 3)) begin
      it = rand_item();
      it.func = FN_READ;
      send(it, 1'b0, '0);
    end
  endtask

  task automatic run_broken();
    send_start(1'($urandom_range(0, 1)), pick_count());
    repeat ($urandom_range(1, 4))
      send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0));
  endtask

  // enough failures in a row to pin the error counter at its ceiling
  task automatic run_storm();
    repeat (270) begin
      if ($urandom_range(0, 1) == 0)
        send_event(SC_OTHER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  task automatic add_row(ref dir_row_t tbl[$], input in_item_t it, input logic typed,
                         input bus_action_t want);
    tbl.push_back({it, typed, want});
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic check_bit(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      fails++;
    end
  endtask

  // receiver: ready pattern switches between a few modes
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = ready_mode_t'($urandom_range(0, 3));
      rdy_left = $urandom_range(20, 150);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      RDY_SELDOM: out_tready <= ($urandom_range(0, 3) == 0);
      default:    out_tready <= (rdy_left % 5 == 0);
    endcase
  end

  bus_action_t got;
  bus_action_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_actions.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, got);
          fails++;
        end else begin
          want = pending_actions.pop_front();
          check_field("drive_data",  want.drive_data,  got.drive_data);
          check_bit("load_data",     want.load_data,   got.load_data);
          check_bit("set_start",     want.set_start,   got.set_start);
          check_bit("clear_start",   want.clear_start, got.clear_start);
          check_bit("set_stop",      want.set_stop,    got.set_stop);
          check_bit("ack_out",       want.ack_out,     got.ack_out);
          check_bit("reset_ctrl",    want.reset_ctrl,  got.reset_ctrl);
          check_bit("busy_res",      want.busy_res,    got.busy_res);
          check_field("error_count", want.error_count, got.error_count);
          check_field("read_value",  want.read_value,  got.read_value);
          check_bit("accepted",      want.accepted,    got.accepted);
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_bus_action(cur_item);
        pending_actions.push_back(cur_typed ? cur_want : want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL smbus_master_byte_sequencer_top");
      $finish;
    end
  end

  dir_row_t dir_tbl[$];
  dir_row_t row;
  int       kind;
  bit       storm_done = 1'b0;

  initial begin
    for (int i = 0; i < BUF_DEPTH_DEF; i++) begin
      txb[i] = '0;
      rxb[i] = '0;
    end
    tx_written = '0;
    rx_written = '0;
    m_addr = '0;
    m_read = 1'b0;
    m_len = '0;
    m_sent = 5'd1;
    m_recv = 5'd1;
    m_busy = 1'b0;
    m_errors = '0;

    // failures while idle, arbitration loss beating a start status
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_OTHER, 0, 0, 0), 1'b1,
            mk_act(0, 0, 0, 1, 0, 0, 1, 0, 1, 0, 1));
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_START_SENT, 1, 1, 0), 1'b1,
            mk_act(0, 0, 0, 1, 0, 0, 1, 0, 2, 0, 1));
    add_row(dir_tbl, mk_item(FN_LOAD, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_act(0, 0, 0, 0, 0, 0, 0, 0, 2, 0, 1));
    add_row(dir_tbl, mk_item(FN_LOAD, 15, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_act(0, 0, 0, 0, 0, 0, 0, 0, 2, 0, 1));
    add_row(dir_tbl, mk_item(FN_LOAD, 1, 8'hA5, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    // write of two bytes, clearing errors; second start refused while busy
    add_row(dir_tbl, mk_item(FN_START, 0, 0, 8'hFF, 0, 2, 1, 0, 0, 0, 0), 1'b1,
            mk_act(0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1));
    add_row(dir_tbl, mk_item(FN_START, 0, 0, 8'h00, 1, 16, 1, 0, 0, 0, 0), 1'b1,
            mk_act(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_START_SENT, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_DATA_SENT, 1, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_DATA_SENT, 1, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_DATA_SENT, 1, 0, 0), 1'b0, '0);
    // read of two bytes: address ack does nothing, last byte gets NACK and stop
    add_row(dir_tbl, mk_item(FN_START, 0, 0, 8'h00, 1, 2, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_START_SENT, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_DATA_SENT, 1, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_BYTE_RECV, 0, 0, 8'h00), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_BYTE_RECV, 0, 0, 8'hFF), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    // zero-length write: address only, then stop
    add_row(dir_tbl, mk_item(FN_START, 0, 0, 8'h5A, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_START_SENT, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_DATA_SENT, 1, 0, 0), 1'b0, '0);
    // oversized count, slave NACK on the address
    add_row(dir_tbl, mk_item(FN_START, 0, 0, 8'hA5, 0, 31, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_START_SENT, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_DATA_SENT, 0, 0, 0), 1'b0, '0);
    // zero-length read still takes one byte
    add_row(dir_tbl, mk_item(FN_START, 0, 0, 8'h3C, 1, 0, 1, 0, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_START_SENT, 0, 0, 0), 1'b0, '0);
    add_row(dir_tbl, mk_item(FN_EVENT, 0, 0, 0, 0, 0, 0, SC_BYTE_RECV, 0, 0, 8'h3C), 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      send(row.it, row.typed, row.want);
    end

    while (n_sent < ITEM_GOAL) begin
      if (!storm_done && n_sent >= 400) begin
        run_storm();
        storm_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) run_write();
      else if (kind < 80) run_read();
      else if (kind < 90) repeat ($urandom_range(1, 3)) send(rand_item(), 1'b0, '0);
      else run_broken();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0 && pending_actions.size() == 0) begin
      $display("PASS smbus_master_byte_sequencer_top");
    end else begin
      $display("FAIL smbus_master_byte_sequencer_top");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/smbms_pkg.sv
rtl/smbms_ram.sv
rtl/smbms_ctrl.sv
rtl/smbms_out.sv
rtl/smbus_master_byte_sequencer_top.sv
tb/tb_smbus_master_byte_sequencer_top.sv
